@@ hw/rtl/adt_pkg.sv @@
package adt_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD        = 2'd0,
    FUNC_CANCEL_REM = 2'd1,
    FUNC_CANCEL_0   = 2'd2,
    FUNC_CHECK      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_SEC,
    S_ADD_SEC,
    S_MUL_USEC,
    S_ADD_USEC,
    S_WRITE,
    S_SCAN,
    S_DIV,
    S_EMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] event_id;
    logic [7:0]  thread_id;
  } entry_t;

  localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;
  localparam logic [63:0] NS_PER_USEC = 64'd1000;

endpackage

@@ hw/rtl/adt_cell.sv @@
// one table slot; shifts toward head when a lower slot is removed
module adt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  adt_pkg::entry_t  load_entry,
  input  logic             shift,
  input  adt_pkg::entry_t  up_entry,
  input  logic             up_valid,
  output adt_pkg::entry_t  entry,
  output logic             valid
);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= up_entry;
    end else if (load) begin
      entry <= load_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= up_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/adt_divider.sv @@
// ceiling of a 64-bit nanosecond count divided by 1e9
// 1e9 = 2^9 * 1953125: the power of two is shifted out, the odd part is
// handled by a multiply with its reciprocal, which is low by at most one
module adt_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [34:0] quotient_ceil
);

  localparam logic [20:0] ODD_DIV = 21'd1953125;
  localparam logic [55:0] RECIP   = 56'((128'd1 << 76) / 128'd1953125);

  logic [54:0]  x;
  logic         low_nz;
  logic [110:0] acc;
  logic [34:0]  q0;
  logic [21:0]  r;
  logic [2:0]   step;
  logic         busy;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  part;
  logic [110:0] part_sh;
  logic [55:0]  qd;
  logic [55:0]  x_minus;
  logic         fix;
  logic [34:0]  q_fix;
  logic         r_nz;

  // one 32x32 partial product of x * RECIP per cycle
  assign mul_a = step[1] ? {9'd0, x[54:32]} : x[31:0];
  assign mul_b = step[0] ? {8'd0, RECIP[55:32]} : RECIP[31:0];
  assign part  = mul_a * mul_b;

  always_comb begin
    if (step == 3'd0) begin
      part_sh = {47'd0, part};
    end else if (step == 3'd3) begin
      part_sh = {part[46:0], 64'd0};
    end else begin
      part_sh = {15'd0, part, 32'd0};
    end
  end

  // remainder of the estimate, then the single correction step
  assign qd      = {21'd0, q0} * {35'd0, ODD_DIV};
  assign x_minus = {1'b0, x} - qd;
  assign fix     = (r >= {1'b0, ODD_DIV});
  assign q_fix   = fix ? (q0 + 35'd1) : q0;
  assign r_nz    = fix ? (r != {1'b0, ODD_DIV}) : (r != 22'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        x      <= dividend[63:9];
        low_nz <= |dividend[8:0];
        acc    <= '0;
        step   <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        case (step)
          3'd4: q0 <= acc[110:76];
          3'd5: r  <= x_minus[21:0];
          3'd6: begin
            quotient_ceil <= q_fix + {34'd0, (r_nz | low_nz)};
            done          <= 1'b1;
            busy          <= 1'b0;
          end
          default: acc <= acc + part_sh;
        endcase
      end
    end
  end

endmodule

@@ hw/rtl/alarm_deadline_table.sv @@
// alarm deadline table
// input channel (valid/ready) carries func, event_id, thread_id, secs, usecs
// and now_ns; output channel (valid/ready) carries zero or more result
// transactions, the final one of each input marked by last
// one input is processed at a time; ready is high only while idle
// add: two 32x32 multiplies, two saturating adds, then the write
// cancel: scans the slots in order (up to TABLE_DEPTH), then runs the
// reciprocal divider for a cancel that reports remaining time
// check: scans the slots in order; expired slots are shifted out of the
// chain one at a time as each fired transaction is sent
// the table is a chain of cells; removing a slot shifts every later cell
// down by one, all in the same cycle
// rst clears the occupancy bits and the controller; stored payload is left
// a stalled receiver simply holds the result register and the scan
module alarm_deadline_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] event_id,
  input  logic [7:0]  thread_id,
  input  logic [31:0] secs,
  input  logic [31:0] usecs,
  input  logic [63:0] now_ns,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_event,
  output logic [7:0]  out_thread,
  output logic [2:0]  status,
  output logic [34:0] remaining_secs,
  output logic        last
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  adt_pkg::state_t state, state_next;
  adt_pkg::entry_t cell_entry [TABLE_DEPTH];
  logic            cell_valid [TABLE_DEPTH];
  logic            cell_load  [TABLE_DEPTH];
  logic            cell_shift [TABLE_DEPTH];

  // latched request
  logic [1:0]  r_func;
  logic [15:0] r_event;
  logic [7:0]  r_thread;
  logic [31:0] r_secs;
  logic [31:0] r_usecs;
  logic [63:0] r_now;
  logic [63:0] dl;
  logic [63:0] prod;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [63:0]   diff;
  logic          div_start;
  logic          div_done;
  logic [34:0]   div_q;
  logic          drop;
  logic          more_expired;

  adt_pkg::entry_t cur;
  logic            cur_valid;
  logic [64:0]     sum;
  logic            idx_end;

  assign cur       = cell_entry[idx];
  assign cur_valid = cell_valid[idx];
  assign sum       = {1'b0, dl} + {1'b0, prod};
  assign idx_end   = ({{(CW-IW){1'b0}}, idx} + CW'(1)) >= count;
  assign in_ready  = (state == adt_pkg::S_IDLE);
  assign diff      = cur.deadline - r_now;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    adt_pkg::entry_t up_e;
    logic            up_v;
    if (g == TABLE_DEPTH - 1) begin : g_top
      assign up_e = cell_entry[g];
      assign up_v = 1'b0;
    end else begin : g_mid
      assign up_e = cell_entry[g+1];
      assign up_v = cell_valid[g+1];
    end
    assign cell_load[g]  = (state == adt_pkg::S_WRITE) && (count == CW'(g));
    assign cell_shift[g] = drop && (IW'(g) >= idx);
    adt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (cell_load[g]),
      .load_entry({dl, r_event, r_thread}),
      .shift     (cell_shift[g]),
      .up_entry  (up_e),
      .up_valid  (up_v),
      .entry     (cell_entry[g]),
      .valid     (cell_valid[g])
    );
  end

  adt_divider u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (div_start),
    .dividend     (diff),
    .done         (div_done),
    .quotient_ceil(div_q)
  );

  // look ahead for a later expired slot; if there is one, a fired transaction clears last
  always_comb begin
    more_expired = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (IW'(k) > idx && cell_valid[k] && cell_entry[k].deadline <= r_now) begin
        more_expired = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      adt_pkg::S_IDLE: begin
        if (in_valid) begin
          if (func == adt_pkg::FUNC_ADD) begin
            state_next = (count >= CW'(TABLE_DEPTH)) ? adt_pkg::S_OUT : adt_pkg::S_MUL_SEC;
          end else begin
            state_next = (count == '0) ?
              ((func == adt_pkg::FUNC_CHECK) ? adt_pkg::S_IDLE : adt_pkg::S_OUT) :
              adt_pkg::S_SCAN;
          end
        end
      end
      adt_pkg::S_MUL_SEC:  state_next = adt_pkg::S_ADD_SEC;
      adt_pkg::S_ADD_SEC:  state_next = adt_pkg::S_MUL_USEC;
      adt_pkg::S_MUL_USEC: state_next = adt_pkg::S_ADD_USEC;
      adt_pkg::S_ADD_USEC: state_next = adt_pkg::S_WRITE;
      adt_pkg::S_WRITE:    state_next = adt_pkg::S_OUT;
      adt_pkg::S_SCAN: begin
        if (r_func == adt_pkg::FUNC_CHECK) begin
          if (cur_valid && cur.deadline <= r_now) begin
            state_next = adt_pkg::S_EMIT;
          end else if (idx_end) begin
            state_next = adt_pkg::S_IDLE;
          end
        end else if (cur.event_id == r_event) begin
          state_next = (r_func == adt_pkg::FUNC_CANCEL_REM && cur.deadline >= r_now) ?
                       adt_pkg::S_DIV : adt_pkg::S_OUT;
        end else if (idx_end) begin
          state_next = adt_pkg::S_OUT;
        end
      end
      adt_pkg::S_DIV: if (div_done) state_next = adt_pkg::S_OUT;
      adt_pkg::S_EMIT, adt_pkg::S_OUT: begin
        if (out_valid && out_ready && last) state_next = adt_pkg::S_IDLE;
        else if (out_valid && out_ready) state_next = adt_pkg::S_SCAN;
      end
      default: state_next = adt_pkg::S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    div_start = (state == adt_pkg::S_SCAN) && (r_func == adt_pkg::FUNC_CANCEL_REM) &&
                (cur.event_id == r_event) && (cur.deadline >= r_now);
    drop = 1'b0;
    if (state == adt_pkg::S_SCAN && r_func != adt_pkg::FUNC_CHECK &&
        cur.event_id == r_event) begin
      drop = 1'b1;
    end
    if (state == adt_pkg::S_EMIT && out_valid && out_ready) begin
      drop = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adt_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        adt_pkg::S_IDLE: begin
          if (in_valid) begin
            r_func    <= func;
            r_event   <= event_id;
            r_thread  <= thread_id;
            r_secs    <= secs;
            r_usecs   <= usecs;
            r_now     <= now_ns;
            dl        <= now_ns;
            idx       <= '0;
            out_event      <= event_id;
            out_thread     <= '0;
            remaining_secs <= '0;
            last           <= 1'b1;
            if (func == adt_pkg::FUNC_ADD && count >= CW'(TABLE_DEPTH)) begin
              status    <= adt_pkg::ST_FULL;
              out_valid <= 1'b1;
            end else if (func != adt_pkg::FUNC_ADD && func != adt_pkg::FUNC_CHECK &&
                         count == '0) begin
              status    <= adt_pkg::ST_NOT_FOUND;
              out_valid <= 1'b1;
            end
          end
        end
        adt_pkg::S_MUL_SEC:  prod <= r_secs * adt_pkg::NS_PER_SEC[31:0];
        adt_pkg::S_ADD_SEC:  dl   <= sum[64] ? '1 : sum[63:0];
        adt_pkg::S_MUL_USEC: prod <= r_usecs * adt_pkg::NS_PER_USEC[31:0];
        adt_pkg::S_ADD_USEC: dl   <= sum[64] ? '1 : sum[63:0];
        adt_pkg::S_WRITE: begin
          count     <= count + CW'(1);
          status    <= adt_pkg::ST_ADDED;
          out_valid <= 1'b1;
        end
        adt_pkg::S_SCAN: begin
          if (r_func == adt_pkg::FUNC_CHECK) begin
            if (cur_valid && cur.deadline <= r_now) begin
              out_event  <= cur.event_id;
              out_thread <= cur.thread_id;
              status     <= adt_pkg::ST_FIRED;
              out_valid  <= 1'b1;
              last       <= !more_expired;
            end else if (!idx_end) begin
              idx <= idx + IW'(1);
            end
          end else if (cur.event_id == r_event) begin
            count  <= count - CW'(1);
            status <= adt_pkg::ST_CANCELLED;
            if (!(r_func == adt_pkg::FUNC_CANCEL_REM && cur.deadline >= r_now)) begin
              out_valid <= 1'b1;
            end
          end else if (idx_end) begin
            status    <= adt_pkg::ST_NOT_FOUND;
            out_valid <= 1'b1;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        adt_pkg::S_DIV: begin
          if (div_done) begin
            remaining_secs <= div_q;
            out_valid      <= 1'b1;
          end
        end
        adt_pkg::S_EMIT: begin
          if (out_valid && out_ready) count <= count - CW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
